@@ rtl/rgbpwm_pkg.sv @@
package rgbpwm_pkg;

    localparam int unsigned PhaseW  = 4;
    localparam int unsigned LevelW  = 5;
    localparam int unsigned TargetW = 8;
    localparam int unsigned PeriodW = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TARGET_RED   = 2'd0,
        REG_TARGET_GREEN = 2'd1,
        REG_TARGET_BLUE  = 2'd2,
        REG_FADE_PERIOD  = 2'd3
    } t_cfg_reg;

    // shared per-tick control handed to every channel
    typedef struct packed {
        logic              advance;
        logic              fade_now;
        logic [PhaseW-1:0] phase;
    } t_chan_ctl;

    // 8-bit color to duty level in sixteenths: (x + 1) / 16
    function automatic logic [LevelW-1:0] map_target(input logic [TargetW-1:0] x);
        logic [TargetW:0] sum;
        sum = {1'b0, x} + {{TargetW{1'b0}}, 1'b1};
        return sum[TargetW:TargetW-LevelW+1];
    endfunction

endpackage

@@ rtl/rgbpwm_chan.sv @@
module rgbpwm_chan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rgbpwm_pkg::t_chan_ctl          i_ctl,
    input  logic [rgbpwm_pkg::LevelW-1:0]  i_goal,
    output logic                           o_pin_next,
    output logic [rgbpwm_pkg::LevelW-1:0]  o_level_next,
    output logic                           o_at_goal_next
);
    import rgbpwm_pkg::*;

    logic              r_pin;
    logic [LevelW-1:0] r_level;
    logic              n_pin;
    logic [LevelW-1:0] n_level;

    always_comb begin
        n_pin   = r_pin;
        n_level = r_level;
        if (i_ctl.advance) begin
            // PWM uses the level from before this tick's fade step
            if (i_ctl.phase == '0) begin
                if (r_level != '0) begin
                    n_pin = 1'b1;
                end
            end else if ({1'b0, i_ctl.phase} == r_level) begin
                n_pin = 1'b0;
            end
            if (i_ctl.fade_now) begin
                if (r_level > i_goal) begin
                    n_level = r_level - LevelW'(1);
                end else if (r_level < i_goal) begin
                    n_level = r_level + LevelW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin   <= 1'b0;
            r_level <= '0;
        end else begin
            r_pin   <= n_pin;
            r_level <= n_level;
        end
    end

    assign o_pin_next     = n_pin;
    assign o_level_next   = n_level;
    assign o_at_goal_next = (n_level == i_goal);

endmodule

@@ rtl/rgb_led_pwm_fader.sv @@
// Three-channel PWM driver for an RGB LED with a linear fade engine.
// Input channel (i_in_valid / o_in_ready / i_tick): each transfer is one
// PWM tick request; tick=1 advances the 16-step phase and the fade timer,
// tick=0 leaves all state as is and only reports it.
// Output channel (o_out_valid / i_out_ready): one result per input transfer
// with the pin drives, the three duty levels (0..16) and at_target.
// The result of a transfer is presented on the edge that accepts it.
// Throughput is one item per cycle while the receiver does not stall; state
// updates and the result register load in the same cycle, through a single
// compare/step stage per channel.
// When the receiver stalls, the result register holds and o_in_ready drops
// until the result is taken; a new item enters in the same cycle the old
// result leaves.
// Configuration: i_cfg_we writes register i_cfg_index (0..2 red, green,
// blue targets, 3 fade period) with immediate effect; write only when idle.
// Reset (synchronous, active low) clears targets, period, levels, phase,
// pins and fade timer, and empties the result register.
module rgb_led_pwm_fader (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_tick,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_led_red,
    output logic                            o_led_green,
    output logic                            o_led_blue,
    output logic [rgbpwm_pkg::LevelW-1:0]   o_level_red,
    output logic [rgbpwm_pkg::LevelW-1:0]   o_level_green,
    output logic [rgbpwm_pkg::LevelW-1:0]   o_level_blue,
    output logic                            o_at_target,
    input  logic                            i_cfg_we,
    input  logic [rgbpwm_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [rgbpwm_pkg::CfgDatW-1:0]  i_cfg_data
);
    import rgbpwm_pkg::*;

    logic [TargetW-1:0] r_target_red;
    logic [TargetW-1:0] r_target_green;
    logic [TargetW-1:0] r_target_blue;
    logic [PeriodW-1:0] r_fade_period;
    logic [PhaseW-1:0]  r_phase;
    logic [PeriodW-1:0] r_countdown;
    logic               r_out_valid;

    logic               r_led_red, r_led_green, r_led_blue;
    logic [LevelW-1:0]  r_level_red, r_level_green, r_level_blue;
    logic               r_at_target;

    logic               in_xfer;
    t_chan_ctl          ctl;
    logic [LevelW-1:0]  goal_red, goal_green, goal_blue;
    logic               n_led_red, n_led_green, n_led_blue;
    logic [LevelW-1:0]  n_level_red, n_level_green, n_level_blue;
    logic               at_red, at_green, at_blue;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign ctl.advance  = in_xfer && i_tick;
    assign ctl.fade_now = (r_countdown == '0);
    assign ctl.phase    = r_phase;

    assign goal_red   = map_target(r_target_red);
    assign goal_green = map_target(r_target_green);
    assign goal_blue  = map_target(r_target_blue);

    rgbpwm_chan u_red (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_goal         (goal_red),
        .o_pin_next     (n_led_red),
        .o_level_next   (n_level_red),
        .o_at_goal_next (at_red)
    );

    rgbpwm_chan u_green (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_goal         (goal_green),
        .o_pin_next     (n_led_green),
        .o_level_next   (n_level_green),
        .o_at_goal_next (at_green)
    );

    rgbpwm_chan u_blue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_goal         (goal_blue),
        .o_pin_next     (n_led_blue),
        .o_level_next   (n_level_blue),
        .o_at_goal_next (at_blue)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_red   <= '0;
            r_target_green <= '0;
            r_target_blue  <= '0;
            r_fade_period  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TARGET_RED:   r_target_red   <= i_cfg_data[TargetW-1:0];
                REG_TARGET_GREEN: r_target_green <= i_cfg_data[TargetW-1:0];
                REG_TARGET_BLUE:  r_target_blue  <= i_cfg_data[TargetW-1:0];
                REG_FADE_PERIOD:  r_fade_period  <= i_cfg_data[PeriodW-1:0];
                default: ;
            endcase
        end
    end

    // phase counter and fade timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_countdown <= '0;
        end else if (ctl.advance) begin
            r_phase <= r_phase + PhaseW'(1);
            if (ctl.fade_now) begin
                r_countdown <= r_fade_period;
            end else begin
                r_countdown <= r_countdown - PeriodW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register: load on every input transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_led_red     <= n_led_red;
            r_led_green   <= n_led_green;
            r_led_blue    <= n_led_blue;
            r_level_red   <= n_level_red;
            r_level_green <= n_level_green;
            r_level_blue  <= n_level_blue;
            r_at_target   <= at_red && at_green && at_blue;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_red     = r_led_red;
    assign o_led_green   = r_led_green;
    assign o_led_blue    = r_led_blue;
    assign o_level_red   = r_level_red;
    assign o_level_green = r_level_green;
    assign o_level_blue  = r_level_blue;
    assign o_at_target   = r_at_target;

endmodule
